### design/ptsort_pkg.sv
package ptsort_pkg;

   // Defaults for the top-level parameters.
   localparam int DefMaxNodes = 32;
   localparam int DefKeyBits  = 16;

   // Node indices travel in a 5-bit field, so no more than 32 nodes can be named.
   localparam int IdxBits   = 5;
   localparam int IndexSpan = 32;
   // Wide enough to compare an index field with a node count of up to 32.
   localparam int CmpBits   = 6;

   typedef enum logic [1:0] {
      OP_ADD_NODE = 2'd0,
      OP_ADD_EDGE = 2'd1,
      OP_RUN      = 2'd2,
      OP_NOP      = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      op_type             op;
      logic signed [15:0] order_key;
      logic [4:0]         earlier_node;
      logic [4:0]         later_node;
   } req_type;

   typedef struct packed {
      logic [4:0] node_index;
      logic       cycle_error;
      logic       last;
   } rsp_type;

   // Best candidate found so far as it moves along the cell row.
   typedef struct packed {
      logic               found;
      logic [IdxBits-1:0] idx;
   } cand_type;

   // Per-cell commands from the sequencer.
   typedef struct packed {
      logic load;
      logic edge_add;
      logic emit;
      logic run_start;
      logic store_clear;
   } cell_ctl_type;

endpackage

### design/ptsort_cell.sv
module ptsort_cell #(
   parameter int NODES      = 32,
   parameter int KEY_BITS   = 16,
   parameter int CELL_INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ptsort_pkg::cell_ctl_type      ctl,
   input  logic signed [KEY_BITS-1:0]    load_key,
   input  logic [NODES-1:0]              edge_mask,
   input  logic [NODES-1:0]              emitted_vec,
   input  ptsort_pkg::cand_type          cand_in,
   input  logic signed [KEY_BITS-1:0]    cand_key_in,
   output ptsort_pkg::cand_type          cand_out,
   output logic signed [KEY_BITS-1:0]    cand_key_out,
   output logic                          emitted
);
   import ptsort_pkg::*;

   logic signed [KEY_BITS-1:0] key_ff;
   logic [NODES-1:0]           row_ff;
   logic                       loaded_ff;
   logic                       emitted_ff;
   logic                       cand_found_ff;
   logic [IdxBits-1:0]         cand_idx_ff;
   cand_type                   cand_in_sel;
   logic signed [KEY_BITS-1:0] cand_key_ff;
   logic signed [KEY_BITS-1:0] cand_key_sel;
   logic                       ready;
   logic                       take;

   // A node is ready once every predecessor in its row has been emitted.
   assign ready = loaded_ff && !emitted_ff && ((row_ff & ~emitted_vec) == '0);
   // Strict compare keeps the lower index on equal keys.
   assign take  = ready && (!cand_in.found || (key_ff < cand_key_in));

   always_comb begin
      if (take) begin
         cand_in_sel.found = 1'b1;
         cand_in_sel.idx   = IdxBits'(CELL_INDEX);
         cand_key_sel      = key_ff;
      end else begin
         cand_in_sel  = cand_in;
         cand_key_sel = cand_key_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff     <= 1'b0;
         emitted_ff    <= 1'b0;
         cand_found_ff <= 1'b0;
      end else begin
         cand_found_ff <= cand_in_sel.found;
         if (ctl.store_clear) begin
            loaded_ff <= 1'b0;
         end else if (ctl.load) begin
            loaded_ff <= 1'b1;
         end
         if (ctl.run_start) begin
            emitted_ff <= 1'b0;
         end else if (ctl.emit) begin
            emitted_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_idx_ff <= cand_in_sel.idx;
      cand_key_ff <= cand_key_sel;
      if (ctl.load) begin
         key_ff <= load_key;
         row_ff <= '0;
      end else if (ctl.edge_add) begin
         row_ff <= row_ff | edge_mask;
      end
   end

   assign cand_out     = {cand_found_ff, cand_idx_ff};
   assign cand_key_out = cand_key_ff;
   assign emitted      = emitted_ff;

endmodule

### design/priority_topological_sort_unit.sv
// Channel   | Ports                         | Handshake
// ----------+-------------------------------+--------------------------------------------
// request   | start, busy, req_payload      | taken at a rising edge with start high, busy low
// result    | rsp_strobe, rsp_payload       | valid for one cycle while rsp_strobe is high
//
// Adding a node or an edge leaves busy low, and the next request may follow
// at once. A run keeps busy high and yields its results one at a time: a
// candidate wave crosses the registered cell row, and then the sequencer
// issues the result and marks the node emitted.
// Reset clears the node count, the load and emit flags and the sequencer; keys
// and predecessor rows are rewritten on every load. The receiver cannot stall.
module priority_topological_sort_unit #(
   parameter int MAX_NODES = ptsort_pkg::DefMaxNodes,
   parameter int KEY_BITS  = ptsort_pkg::DefKeyBits
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ptsort_pkg::req_type req_payload,
   output logic                rsp_strobe,
   output ptsort_pkg::rsp_type rsp_payload
);
   import ptsort_pkg::*;

   // Nodes beyond the reach of the 5-bit index field are never stored.
   localparam int NODE_LIMIT = (MAX_NODES < IndexSpan) ? MAX_NODES : IndexSpan;
   localparam int CNT_W      = $clog2(NODE_LIMIT + 1);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      done_ff, done_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic                  load_go, edge_go, emit_go, run_go, clear_go;
   logic                  finish;
   logic signed [KEY_BITS-1:0] load_key;
   logic [NODE_LIMIT-1:0] edge_mask;
   logic [NODE_LIMIT-1:0] emitted_vec;

   cand_type                   cand_chain [0:NODE_LIMIT];
   logic signed [KEY_BITS-1:0] key_chain  [0:NODE_LIMIT];
   cand_type                   best;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // The 16-bit key is wrapped or sign extended to the stored key width.
   generate
      if (KEY_BITS <= 16) begin : g_key_narrow
         assign load_key = req_payload.order_key[KEY_BITS-1:0];
      end else begin : g_key_wide
         assign load_key = {{(KEY_BITS-16){req_payload.order_key[15]}},
                            req_payload.order_key};
      end
   endgenerate

   assign edge_mask = {{(NODE_LIMIT-1){1'b0}}, 1'b1} << req_payload.earlier_node;

   // The wave enters the row with no candidate; the last cell holds the winner.
   assign cand_chain[0] = '0;
   assign key_chain[0]  = '0;
   assign best          = cand_chain[NODE_LIMIT];
   assign finish        = (CNT_W'(done_ff + 1'b1) == count_ff);

   generate
      for (genvar i = 0; i < NODE_LIMIT; i++) begin : g_cell
         cell_ctl_type ctl;

         assign ctl.load        = load_go && (count_ff == CNT_W'(i));
         assign ctl.edge_add    = edge_go && (req_payload.later_node == IdxBits'(i));
         assign ctl.emit        = emit_go && (best.idx == IdxBits'(i));
         assign ctl.run_start   = run_go;
         assign ctl.store_clear = clear_go;

         ptsort_cell #(
            .NODES      (NODE_LIMIT),
            .KEY_BITS   (KEY_BITS),
            .CELL_INDEX (i)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctl          (ctl),
            .load_key     (load_key),
            .edge_mask    (edge_mask),
            .emitted_vec  (emitted_vec),
            .cand_in      (cand_chain[i]),
            .cand_key_in  (key_chain[i]),
            .cand_out     (cand_chain[i+1]),
            .cand_key_out (key_chain[i+1]),
            .emitted      (emitted_vec[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         done_ff      <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Sequencer: decodes requests while idle and paces the candidate waves of a run.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      scan_in      = scan_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      load_go      = 1'b0;
      edge_go      = 1'b0;
      emit_go      = 1'b0;
      run_go       = 1'b0;
      clear_go     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_payload.op)
                  OP_ADD_NODE: begin
                     if (count_ff < CNT_W'(NODE_LIMIT)) begin
                        load_go  = 1'b1;
                        count_in = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  OP_ADD_EDGE: begin
                     edge_go = ({1'b0, req_payload.earlier_node} < CmpBits'(count_ff))
                            && ({1'b0, req_payload.later_node} < CmpBits'(count_ff));
                  end
                  OP_RUN: begin
                     if (count_ff == '0) begin
                        clear_go = 1'b1;
                     end else begin
                        run_go   = 1'b1;
                        state_in = ST_SCAN;
                        scan_in  = '0;
                        done_in  = '0;
                     end
                  end
                  OP_NOP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_ff == CNT_W'(NODE_LIMIT)) begin
               // The wave has crossed the whole row with the emit flags stable.
               scan_in      = '0;
               rsp_valid_in = 1'b1;
               if (best.found) begin
                  emit_go            = 1'b1;
                  done_in            = CNT_W'(done_ff + 1'b1);
                  rsp_in.node_index  = best.idx;
                  rsp_in.cycle_error = 1'b0;
                  rsp_in.last        = finish;
                  if (finish) begin
                     state_in = ST_IDLE;
                     clear_go = 1'b1;
                  end
               end else begin
                  // No remaining node is ready, so the rest form a loop.
                  rsp_in.node_index  = '0;
                  rsp_in.cycle_error = 1'b1;
                  rsp_in.last        = 1'b1;
                  state_in           = ST_IDLE;
                  clear_go           = 1'b1;
               end
            end else begin
               scan_in = CNT_W'(scan_ff + 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (clear_go) begin
         count_in = '0;
      end
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### dv/priority_topological_sort_unit_tb.sv
// Self-checking bench for the priority topological sort unit.
//
// An initial block builds the whole request list up front: a short directed
// list, then random graphs. Each graph loads a set of nodes, adds ordering
// edges and ends with a run request. The driver hands the requests to the
// block one at a time and idles between them at random. Whenever the block
// takes a request, the driver feeds that same request to a behavioral copy of
// the sorter. That copy computes the sequence of node indices that the run
// must emit and queues it. The monitor pops one expectation per strobed
// result and compares the fields.
module priority_topological_sort_unit_tb;
   import ptsort_pkg::*;

   localparam int MaxNodes   = DefMaxNodes;
   localparam int KeyBits    = DefKeyBits;
   localparam int NodeLimit  = (MaxNodes < IndexSpan) ? MaxNodes : IndexSpan;
   localparam int CycleLimit = 500000;
   localparam int RandomItems = 135;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   priority_topological_sort_unit #(
      .MAX_NODES (MaxNodes),
      .KEY_BITS  (KeyBits)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // Requests still to be sent, and node indices the block still owes us.
   req_type pending_requests[$];
   rsp_type expected_order[$];

   // Shadow copy of the sorter's store.
   int          node_keys[IndexSpan];
   logic [31:0] pred_rows[IndexSpan];
   int          loaded_count = 0;

   int fail_count  = 0;
   int cycle_count = 0;
   int gap_left    = 0;
   bit no_idle_stretch = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Every failure goes through here. Only the first ten are printed.
   function automatic bit report_allowed();
      fail_count++;
      return fail_count <= 10;
   endfunction

   // The driver usually idles for a random number of cycles after each
   // request, but now and then switches into a stretch with no gaps at all.
   function automatic int draw_gap();
      if ($urandom_range(0, 24) == 0)
         no_idle_stretch = !no_idle_stretch;
      return no_idle_stretch ? 0 : $urandom_range(0, 13);
   endfunction

   // Behavioral sorter. A load appends a node with its key wrapped to the key
   // width. An edge sets one predecessor bit if both nodes exist. A run
   // repeatedly picks the ready node with the smallest key, where ties go to
   // the lower index, and stops with an error result when nothing is ready.
   // The store is empty again after every run.
   task automatic apply_request(input req_type r);
      int          wrapped;
      int          best;
      int          emitted_total;
      bit          found;
      bit          stalled;
      logic [31:0] emitted;
      rsp_type     res;
      case (r.op)
         OP_ADD_NODE: begin
            if (loaded_count < NodeLimit) begin
               wrapped = int'(r.order_key);
               wrapped = (wrapped <<< (32 - KeyBits)) >>> (32 - KeyBits);
               node_keys[loaded_count] = wrapped;
               pred_rows[loaded_count] = '0;
               loaded_count++;
            end
         end
         OP_ADD_EDGE: begin
            if (int'(r.earlier_node) < loaded_count && int'(r.later_node) < loaded_count)
               pred_rows[r.later_node][r.earlier_node] = 1'b1;
         end
         OP_RUN: begin
            emitted       = '0;
            emitted_total = 0;
            stalled       = 1'b0;
            while (!stalled && emitted_total < loaded_count) begin
               found = 1'b0;
               best  = 0;
               for (int i = 0; i < loaded_count; i++) begin
                  if (!emitted[i] && (pred_rows[i] & ~emitted) == '0) begin
                     if (!found || node_keys[i] < node_keys[best]) begin
                        best  = i;
                        found = 1'b1;
                     end
                  end
               end
               if (!found) begin
                  // The remaining nodes wait on each other: a dependency loop.
                  res.node_index  = '0;
                  res.cycle_error = 1'b1;
                  res.last        = 1'b1;
                  stalled         = 1'b1;
               end else begin
                  emitted[best] = 1'b1;
                  emitted_total++;
                  res.node_index  = best[IdxBits-1:0];
                  res.cycle_error = 1'b0;
                  res.last        = (emitted_total == loaded_count);
               end
               expected_order.push_back(res);
            end
            loaded_count = 0;
            for (int i = 0; i < IndexSpan; i++)
               pred_rows[i] = '0;
         end
         default: ;
      endcase
   endtask

   task automatic queue_request(input op_type op, input int key, input int e, input int l);
      req_type r;
      r.op           = op;
      r.order_key    = 16'(key);
      r.earlier_node = 5'(e);
      r.later_node   = 5'(l);
      pending_requests.push_back(r);
   endtask

   // A request with every field random, the operation included.
   task automatic queue_noise();
      queue_request(op_type'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
   endtask

   // One random graph followed by a run. Nodes get hidden ranks, and edges
   // point from lower to higher rank, so the graph is acyclic unless a back
   // edge or a self edge is added on purpose. Returns a count of the loads
   // within the node limit, the edge steps and the run that it queues.
   task automatic queue_graph(input bit force_full, output int used);
      int n;
      int named;
      int key_mode;
      int key;
      int edge_total;
      int a;
      int b;
      int rank[IndexSpan];
      used = 0;
      a    = 0;
      b    = 0;
      case ($urandom_range(0, 19))
         0:       n = $urandom_range(30, 35);
         1, 2:    n = $urandom_range(0, 1);
         default: n = $urandom_range(2, 8);
      endcase
      if (force_full)
         n = NodeLimit + 2;
      named    = (n < NodeLimit) ? n : NodeLimit;
      key_mode = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
         case (key_mode)
            0: key = $urandom;
            1: key = $urandom_range(0, 4) - 2;   // Narrow range, many ties.
            default: key = $urandom_range(0, 1) ? -32768 : 32767;
         endcase
         queue_request(OP_ADD_NODE, key, 0, 0);
         if (i < NodeLimit)
            used++;
      end
      for (int i = 0; i < IndexSpan; i++)
         rank[i] = $urandom;
      edge_total = (named < 2) ? 0 : $urandom_range(0, (named < 8) ? 2 * named : 24);
      for (int i = 0; i < edge_total; i++) begin
         if (i > 0 && $urandom_range(0, 7) == 0) begin
            queue_request(OP_ADD_EDGE, 0, a, b);    // Repeat of the previous edge.
         end else begin
            a = $urandom_range(0, named - 1);
            b = $urandom_range(0, named - 1);
            if (rank[a] > rank[b]) begin
               key = a;
               a   = b;
               b   = key;
            end
            if (a != b)
               queue_request(OP_ADD_EDGE, 0, a, b);
         end
         used++;
         if ($urandom_range(0, 29) == 0)
            queue_noise();
      end
      if (named > 0 && $urandom_range(0, 3) == 0) begin
         a = $urandom_range(0, named - 1);
         b = $urandom_range(0, named - 1);
         case ($urandom_range(0, 2))
            0: queue_request(OP_ADD_EDGE, 0, a, a);              // Self edge.
            1: queue_request(OP_ADD_EDGE, 0, (rank[a] > rank[b]) ? a : b,
                             (rank[a] > rank[b]) ? b : a);       // Back edge.
            default: queue_request(OP_ADD_EDGE, 0, $urandom_range(named, 31), a);
         endcase
         used++;
      end
      queue_request(OP_RUN, 0, 0, 0);
      used++;
   endtask

   // Driver. A request counts as taken at an edge where start is high and
   // busy is low. After that the driver waits out the gap drawn for that
   // request before it presents the next one. With a gap of zero, start
   // simply stays high and the payload changes.
   always @(posedge clock) begin
      logic drive_start;
      drive_start = start;
      if (reset) begin
         drive_start = 1'b0;
      end else begin
         if (start && !busy) begin
            apply_request(req_payload);
            drive_start = 1'b0;
         end
         if (!drive_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() > 0) begin
               req_payload <= pending_requests.pop_front();
               drive_start = 1'b1;
               gap_left    = draw_gap();
            end
         end
      end
      start <= drive_start;
   end

   // Monitor. A result is valid for exactly one cycle while rsp_strobe is
   // high, and it is matched against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_order.size() == 0) begin
            if (report_allowed())
               $display("unexpected result: node_index %0d cycle_error %0b last %0b",
                        rsp_payload.node_index, rsp_payload.cycle_error, rsp_payload.last);
         end else begin
            want = expected_order.pop_front();
            if (rsp_payload.node_index !== want.node_index
                || rsp_payload.cycle_error !== want.cycle_error
                || rsp_payload.last !== want.last) begin
               if (report_allowed())
                  $display({"mismatch: expected node_index %0d cycle_error %0b last %0b,",
                            " got node_index %0d cycle_error %0b last %0b"},
                           want.node_index, want.cycle_error, want.last,
                           rsp_payload.node_index, rsp_payload.cycle_error,
                           rsp_payload.last);
            end
         end
      end
   end

   // Watchdog on the total run time.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int random_used;
      int graph_used;
      random_used = 0;
      for (int i = 0; i < IndexSpan; i++) begin
         node_keys[i] = 0;
         pred_rows[i] = '0;
      end

      // Directed part. It starts with an empty run and an idle operation.
      queue_request(OP_RUN, 0, 0, 0);
      queue_request(OP_NOP, 16'h5a5a, 21, 10);
      // Key extremes with ties. A duplicate edge, and edges that name a node
      // that was never loaded.
      queue_request(OP_ADD_NODE, 32767, 0, 0);
      queue_request(OP_ADD_NODE, -32768, 0, 0);
      queue_request(OP_ADD_NODE, 0, 0, 0);
      queue_request(OP_ADD_NODE, -32768, 0, 0);
      queue_request(OP_ADD_NODE, 32767, 0, 0);
      queue_request(OP_ADD_EDGE, 0, 2, 1);
      queue_request(OP_ADD_EDGE, 0, 2, 1);
      queue_request(OP_ADD_EDGE, 0, 31, 0);
      queue_request(OP_ADD_EDGE, 0, 0, 31);
      queue_request(OP_ADD_EDGE, 0, 4, 3);
      queue_request(OP_RUN, 0, 0, 0);
      // A self edge. The nodes that are ready come out first, then the error.
      queue_request(OP_ADD_NODE, 5, 0, 0);
      queue_request(OP_ADD_NODE, 5, 0, 0);
      queue_request(OP_ADD_NODE, -7, 0, 0);
      queue_request(OP_ADD_EDGE, 0, 1, 1);
      queue_request(OP_RUN, 0, 0, 0);
      // A two-node loop. The error comes at once.
      queue_request(OP_ADD_NODE, 1, 0, 0);
      queue_request(OP_ADD_NODE, 2, 0, 0);
      queue_request(OP_ADD_EDGE, 0, 0, 1);
      queue_request(OP_ADD_EDGE, 0, 1, 0);
      queue_request(OP_RUN, 0, 0, 0);
      // An idle operation with all bits set, and an edge into an empty store.
      queue_request(OP_NOP, -1, 31, 31);
      queue_request(OP_ADD_EDGE, 0, 0, 0);

      // Random part. The first graph overfills the store, so the loads past
      // the limit are ignored and the high index bits get exercised.
      while (random_used < RandomItems) begin
         queue_graph(random_used == 0, graph_used);
         random_used += graph_used;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Sample on the falling edge so that the driver and the monitor have
      // settled for the cycle.
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || start || busy || expected_order.size() != 0);
      repeat (2 * (NodeLimit + 1)) @(negedge clock);

      if (expected_order.size() != 0 && report_allowed())
         $display("%0d expected results never arrived", expected_order.size());
      if (fail_count == 0 && expected_order.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
